// File: rtl/tked_pkg.sv
// types and constants for the terminal key escape decoder
// no dependencies; imported by terminal_key_escape_decoder
package tked_pkg;

    localparam int TimeoutWidth = 20;
    localparam logic [TimeoutWidth-1:0] TimeoutReset = 20'd1000;
    localparam logic [TimeoutWidth-1:0] WaitMax = {TimeoutWidth{1'b1}};

    localparam logic [7:0] ByteEsc     = 8'h1b;
    localparam logic [7:0] ByteBracket = 8'h5b;
    localparam logic [7:0] ByteTilde   = 8'h7e;
    localparam logic [7:0] ByteUp      = 8'h41;
    localparam logic [7:0] ByteDown    = 8'h42;
    localparam logic [7:0] ByteRight   = 8'h43;
    localparam logic [7:0] ByteLeft    = 8'h44;
    localparam logic [7:0] ByteEnd     = 8'h46;
    localparam logic [7:0] ByteHome    = 8'h48;
    localparam logic [7:0] ByteDigit3  = 8'h33;
    localparam logic [7:0] ByteDigit5  = 8'h35;
    localparam logic [7:0] ByteDigit6  = 8'h36;
    localparam logic [7:0] ByteDigit7  = 8'h37;
    localparam logic [7:0] ByteDigit8  = 8'h38;

    localparam logic OpByte = 1'b0;
    localparam logic OpTick = 1'b1;

    typedef enum logic [3:0] {
        KEY_PLAIN  = 4'd0,
        KEY_ESC    = 4'd1,
        KEY_DELETE = 4'd2,
        KEY_UP     = 4'd3,
        KEY_DOWN   = 4'd4,
        KEY_RIGHT  = 4'd5,
        KEY_LEFT   = 4'd6,
        KEY_PGUP   = 4'd7,
        KEY_PGDOWN = 4'd8,
        KEY_HOME   = 4'd9,
        KEY_END    = 4'd10
    } key_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DISCARD = 5'b00010,
        ST_ESC     = 5'b00100,
        ST_BRACKET = 5'b01000,
        ST_TILDE   = 5'b10000
    } parse_state_t;

    typedef struct packed {
        logic      last;
        logic [7:0] key_byte;
        key_kind_t  key_kind;
    } result_t;

endpackage

// File: rtl/terminal_key_escape_decoder.sv
// terminal key escape decoder: bytes and ticks in, decoded keys out
// depends on tked_pkg for key codes, parse states and the result word
//
// channel   direction  handshake             payload
// s_axis    in         s_tvalid / s_tready   s_tdata[7:0] byte_value, s_tuser operation
// m_axis    out        m_tvalid / m_tready   m_tdata[7:0] key_byte, m_tuser[3:0] key_kind, m_tlast
// cfg       in         cfg_valid / cfg_ready cfg_data[19:0] escape_timeout
//
// one word is decoded in the cycle it is accepted and its zero, one or two keys land
// in a two-entry result register; keys leave one a cycle while m_tready is high
// a new word is taken while the result register is empty or its last key is leaving, so
// one-key words flow at one a cycle while m_tready is high and a two-key word holds the next
// reset clears parse state, wait counter and result count; timeout returns to 1000
// a stall on m_axis holds the result register and, once it holds a key, s_tready
module terminal_key_escape_decoder
    import tked_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] key_byte
    output logic [3:0]  m_tuser,   // [3:0] key_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data   // [19:0] escape_timeout
);

    logic [TimeoutWidth-1:0] timeout_reg;
    logic [TimeoutWidth-1:0] wait_reg, wait_next;
    parse_state_t            state_reg, state_next, state_settled;
    key_kind_t               pend_reg, pend_next;
    result_t                 q0_reg, q1_reg;
    logic [1:0]              count_reg;

    logic      in_acc, out_acc, expired;
    logic      esc_settle;
    logic [1:0] h_n, r_n;
    result_t   h0, h1, r0, r1;

    assign cfg_ready = 1'b1;
    assign out_acc   = m_tvalid && m_tready;
    assign s_tready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign in_acc    = s_tvalid && s_tready;

    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = q0_reg.key_byte;
    assign m_tuser  = q0_reg.key_kind;
    assign m_tlast  = q0_reg.last;

    // an expired wait is settled before the word itself
    assign expired = ((state_reg == ST_ESC) || (state_reg == ST_DISCARD))
                     && (wait_reg >= timeout_reg);
    assign esc_settle    = expired && (state_reg == ST_ESC);
    assign state_settled = expired ? ST_IDLE : state_reg;

    always_comb
    begin
        state_next = state_settled;
        pend_next  = pend_reg;
        wait_next  = wait_reg;
        h_n        = 2'd0;
        h0         = '{last: 1'b0, key_byte: 8'd0, key_kind: KEY_PLAIN};
        h1         = '{last: 1'b0, key_byte: 8'd0, key_kind: KEY_PLAIN};
        if (s_tuser == OpTick)
        begin
            if (wait_reg != WaitMax)
            begin
                wait_next = wait_reg + 1'b1;
            end
        end
        else
        begin
            unique case (state_settled)
                ST_DISCARD:
                begin
                end
                ST_ESC:
                begin
                    if (s_tdata == ByteBracket)
                    begin
                        state_next = ST_BRACKET;
                    end
                    else
                    begin
                        // lone esc, then the byte is taken again from idle
                        h0.key_kind = KEY_ESC;
                        h_n         = 2'd1;
                        state_next  = ST_IDLE;
                        if (s_tdata == ByteEsc)
                        begin
                            state_next = ST_ESC;
                            wait_next  = '0;
                        end
                        else
                        begin
                            h1.key_kind = KEY_PLAIN;
                            h1.key_byte = s_tdata;
                            h_n         = 2'd2;
                        end
                    end
                end
                ST_BRACKET:
                begin
                    state_next = ST_IDLE;
                    h_n        = 2'd1;
                    unique case (s_tdata)
                        ByteUp:     h0.key_kind = KEY_UP;
                        ByteDown:   h0.key_kind = KEY_DOWN;
                        ByteRight:  h0.key_kind = KEY_RIGHT;
                        ByteLeft:   h0.key_kind = KEY_LEFT;
                        ByteEnd:    h0.key_kind = KEY_END;
                        ByteHome:   h0.key_kind = KEY_HOME;
                        ByteDigit3: begin state_next = ST_TILDE; pend_next = KEY_DELETE; h_n = 2'd0; end
                        ByteDigit5: begin state_next = ST_TILDE; pend_next = KEY_PGUP;   h_n = 2'd0; end
                        ByteDigit6: begin state_next = ST_TILDE; pend_next = KEY_PGDOWN; h_n = 2'd0; end
                        ByteDigit7: begin state_next = ST_TILDE; pend_next = KEY_HOME;   h_n = 2'd0; end
                        ByteDigit8: begin state_next = ST_TILDE; pend_next = KEY_END;    h_n = 2'd0; end
                        default:
                        begin
                            state_next = ST_DISCARD;
                            wait_next  = '0;
                            h_n        = 2'd0;
                        end
                    endcase
                end
                ST_TILDE:
                begin
                    if (s_tdata == ByteTilde)
                    begin
                        state_next  = ST_IDLE;
                        h0.key_kind = pend_reg;
                        h_n         = 2'd1;
                    end
                    else
                    begin
                        state_next = ST_DISCARD;
                        wait_next  = '0;
                    end
                end
                default:
                begin
                    if (s_tdata == ByteEsc)
                    begin
                        state_next = ST_ESC;
                        wait_next  = '0;
                    end
                    else
                    begin
                        state_next  = ST_IDLE;
                        h0.key_kind = KEY_PLAIN;
                        h0.key_byte = s_tdata;
                        h_n         = 2'd1;
                    end
                end
            endcase
        end
    end

    // merge the settled esc ahead of the word's own keys and mark the final one
    always_comb
    begin
        if (esc_settle)
        begin
            r0 = '{last: 1'b0, key_byte: 8'd0, key_kind: KEY_ESC};
            r1 = h0;
            r_n = h_n + 2'd1;
        end
        else
        begin
            r0  = h0;
            r1  = h1;
            r_n = h_n;
        end
        r0.last = r_n == 2'd1;
        r1.last = r_n == 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TimeoutReset;
            state_reg   <= ST_IDLE;
            pend_reg    <= KEY_PLAIN;
            wait_reg    <= '0;
            count_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (in_acc)
            begin
                state_reg <= state_next;
                pend_reg  <= pend_next;
                wait_reg  <= wait_next;
                count_reg <= r_n;
            end
            else if (out_acc)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // result register holds no reset: count_reg qualifies it
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q0_reg <= r0;
            q1_reg <= r1;
        end
        else if (out_acc)
        begin
            q0_reg <= q1_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (!q0_reg.last && q1_reg.last))
        else $error("two held keys not from one word");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !s_tready)
        else $error("word taken with full result register");

    a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(wait_reg))
        else $error("wait counter moved without a word");

endmodule
